### src/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, limits and the UTF-8 sequence classifier.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int CNT_W = 21;
  // bytes taken per string; counts stay below 2^CNT_W, so no wrap occurs
  localparam logic [CNT_W:0] MAX_BYTES = (CNT_W + 1)'(1048576);

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    cnt_t       target_units;
  } in_word_t;

  typedef struct packed {
    cnt_t unit_count;
    cnt_t byte_offset;
    logic splits_pair;
  } out_word_t;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] E0_B1_MIN  = 8'hA0;  // also first surrogate byte after ED
  localparam logic [7:0] SURR_LEAD  = 8'hED;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] F0_B1_MIN  = 8'h90;  // also range limit after F4

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  // length of the item led by b0, given avail known bytes (1..4)
  function automatic logic [2:0] item_len(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] avail);
    logic [2:0] len;
    len = 3'd1;
    if (b0 <= ASCII_MAX) begin
      len = 3'd1;
    end else if (b0 >= LEAD2_MIN && b0 <= LEAD2_MAX && avail >= 3'd2 && is_cont(b1)) begin
      len = 3'd2;
    end else if (b0 >= LEAD3_MIN && b0 <= LEAD3_MAX && avail >= 3'd3 &&
                 is_cont(b1) && is_cont(b2) &&
                 !(b0 == LEAD3_MIN && b1 < E0_B1_MIN) &&
                 !(b0 == SURR_LEAD && b1 >= E0_B1_MIN)) begin
      len = 3'd3;
    end else if (b0 >= LEAD4_MIN && b0 <= LEAD4_MAX && avail >= 3'd4 &&
                 is_cont(b1) && is_cont(b2) && is_cont(b3) &&
                 !(b0 == LEAD4_MIN && b1 < F0_B1_MIN) &&
                 !(b0 == LEAD4_MAX && b1 >= F0_B1_MIN)) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

### src/u8u16_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_core
// Look-ahead window and counters; forms the result on the string's last word.
// ----------------------------------------------------------------------------
module u8u16_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  u8u16_pkg::in_word_t  word,
  output logic                 done,
  output u8u16_pkg::out_word_t result
);

  logic [7:0]      win [3];
  logic [1:0]      fill;
  logic [1:0]      skip;
  u8u16_pkg::cnt_t bytes_seen;
  u8u16_pkg::cnt_t units_seen;
  u8u16_pkg::cnt_t held_target;
  logic            found;
  u8u16_pkg::cnt_t found_offset;
  logic            split;
  logic            open;

  logic [7:0]      win_next [3];
  logic [1:0]      fill_next;
  logic [1:0]      skip_next;
  u8u16_pkg::cnt_t bytes_next;
  u8u16_pkg::cnt_t units_next;
  u8u16_pkg::cnt_t held_c;
  logic            found_next;
  u8u16_pkg::cnt_t found_offset_next;
  logic            split_next;

  logic [7:0]                  w [4];
  logic [2:0]                  n;
  logic [2:0]                  r;
  logic [2:0]                  lens [4];
  logic [u8u16_pkg::CNT_W:0]   diff;

  always_comb begin
    logic [1:0]      fill_c;
    logic [1:0]      sk;
    u8u16_pkg::cnt_t bytes_c;
    u8u16_pkg::cnt_t units_c;
    logic            fnd;
    logic            spl;
    logic            fnew;
    logic [3:0]      du;
    logic [2:0]      db;
    logic [2:0]      fdb;
    logic [1:0]      u;
    logic            append;

    // a fresh string starts from cleared state
    fill_c  = open ? fill : 2'd0;
    sk      = open ? skip : 2'd0;
    bytes_c = open ? bytes_seen : '0;
    units_c = open ? units_seen : '0;
    held_c  = open ? held_target : word.target_units;
    fnd     = open ? found : 1'b0;
    spl     = open ? split : 1'b0;

    for (int i = 0; i < 4; i++) begin
      w[i] = (i < 3 && 2'(i) < fill_c) ? win[i % 3] : 8'h00;
    end
    append = ({1'b0, bytes_c} + (u8u16_pkg::CNT_W + 1)'(fill_c)) < u8u16_pkg::MAX_BYTES;
    if (append) begin
      w[fill_c] = word.data_byte;
    end
    n = 3'(fill_c) + 3'(append);
    r = word.last_byte ? n : ((n == 3'd4) ? 3'd1 : 3'd0);

    for (int k = 0; k < 4; k++) begin
      lens[k] = u8u16_pkg::item_len(w[k],
                                    (k + 1 < 4) ? w[(k + 1) % 4] : 8'h00,
                                    (k + 2 < 4) ? w[(k + 2) % 4] : 8'h00,
                                    (k + 3 < 4) ? w[(k + 3) % 4] : 8'h00,
                                    n - 3'(k));
    end

    // target relative to the unit count at the start of this word
    diff = {1'b0, held_c} - {1'b0, units_c};

    du   = 4'd0;
    db   = 3'd0;
    fdb  = 3'd0;
    fnew = 1'b0;
    for (int k = 0; k < 4; k++) begin
      u = 2'd1;
      if (3'(k) < r) begin
        if (sk != 2'd0) begin
          sk = sk - 2'd1;
        end else begin
          u = (lens[k] == 3'd4) ? 2'd2 : 2'd1;
          if (!fnd) begin
            if (diff == (u8u16_pkg::CNT_W + 1)'(du)) begin
              fnd  = 1'b1;
              fnew = 1'b1;
              fdb  = db;
            end else if (u == 2'd2 &&
                         diff == (u8u16_pkg::CNT_W + 1)'(du) + (u8u16_pkg::CNT_W + 1)'(1)) begin
              fnd  = 1'b1;
              fnew = 1'b1;
              fdb  = db;
              spl  = 1'b1;
            end
          end
          du = du + 4'(u);
          sk = 2'(lens[k] - 3'd1);
        end
        db = db + 3'd1;
      end
    end

    bytes_next        = bytes_c + u8u16_pkg::CNT_W'(db);
    units_next        = units_c + u8u16_pkg::CNT_W'(du);
    found_offset_next = fnew ? bytes_c + u8u16_pkg::CNT_W'(fdb) : found_offset;
    found_next        = fnd;
    split_next        = spl;
    skip_next         = sk;
    fill_next         = 2'(n - r);
    for (int i = 0; i < 3; i++) begin
      win_next[i] = (r != 3'd0) ? w[i + 1] : w[i];
    end
  end

  assign done               = take && word.last_byte;
  assign result.unit_count  = units_next;
  assign result.byte_offset = found_next ? found_offset_next : bytes_next;
  assign result.splits_pair = found_next && split_next;

  always_ff @(posedge clk) begin
    if (rst || done) begin
      for (int i = 0; i < 3; i++) begin
        win[i] <= 8'h00;
      end
      fill         <= 2'd0;
      skip         <= 2'd0;
      bytes_seen   <= '0;
      units_seen   <= '0;
      held_target  <= '0;
      found        <= 1'b0;
      found_offset <= '0;
      split        <= 1'b0;
      open         <= 1'b0;
    end else if (take) begin
      win          <= win_next;
      fill         <= fill_next;
      skip         <= skip_next;
      bytes_seen   <= bytes_next;
      units_seen   <= units_next;
      held_target  <= held_c;
      found        <= found_next;
      found_offset <= found_offset_next;
      split        <= split_next;
      open         <= 1'b1;
    end
  end

endmodule

### src/utf8_to_utf16_offset_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_offset_counter
// Validates a UTF-8 string word by word and reports its UTF-16 length, the
// byte offset of a target UTF-16 index and whether it splits a pair.
// ----------------------------------------------------------------------------
//  channel | valid     | ready     | payload  | word
//  input   | byte_valid| byte_ready| byte_word| one string byte + last flag
//  output  | res_valid | res_ready | res_word | one result per string
//
// One byte is taken every cycle while byte_ready is high; a string's result is registered
// from its last byte into the result register, or into one spare slot if that is still held.
// byte_ready drops only while both result slots are full.
// Reset (rst, synchronous) clears the window, counters and both slots; no
// clearing pass is needed.
module utf8_to_utf16_offset_counter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  u8u16_pkg::in_word_t  byte_word,
  output logic                 res_valid,
  input  logic                 res_ready,
  output u8u16_pkg::out_word_t res_word
);

  logic                 take;
  logic                 done;
  u8u16_pkg::out_word_t result;
  logic                 spare_valid;
  u8u16_pkg::out_word_t spare;
  logic                 pop;

  assign byte_ready = !spare_valid;
  assign take       = byte_valid && byte_ready;
  assign pop        = res_valid && res_ready;

  u8u16_core u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .word   (byte_word),
    .done   (done),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (pop) begin
        res_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end
    end else if (done) begin
      if (!res_valid || pop) begin
        res_valid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (pop) begin
        res_word <= spare;
      end
    end else if (done) begin
      if (!res_valid || pop) begin
        res_word <= result;
      end else begin
        spare <= result;
      end
    end
  end

  // spare slot is only ever filled behind a waiting result
  assert property (@(posedge clk) disable iff (rst) spare_valid |-> res_valid)
    else $error("spare slot valid without a result in the output register");

  // a last byte is always followed on the next cycle by a valid result on the port
  assert property (@(posedge clk) disable iff (rst)
                   (take && byte_word.last_byte) |=> res_valid)
    else $error("last byte accepted but no result presented");

  // draining with a spare queued keeps a result on the port
  assert property (@(posedge clk) disable iff (rst)
                   (pop && spare_valid) |=> (res_valid && !spare_valid))
    else $error("spare result lost when output register drained");

endmodule
